### hdl/sfsh_pkg.sv
// Package: shared types, constants and mixing functions of the string hash.
`default_nettype none
package sfsh_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned HALF_W  = 16;
   localparam int unsigned BYTE_W  = 8;

   localparam logic [COUNT_W-1:0] TAIL_NONE  = 3'd0;
   localparam logic [COUNT_W-1:0] TAIL_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] TAIL_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] TAIL_THREE = 3'd3;

   // Last-item hash on its way from the mix stage to the finish stage.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] hash;
   } tail_type;

   // Widens a single tail byte, as signed or unsigned char.
   function automatic logic [WORD_W-1:0] single_byte(input logic [BYTE_W-1:0] b,
                                                     input logic             sgn);
      return {{(WORD_W-BYTE_W){sgn & b[BYTE_W-1]}}, b};
   endfunction

   // Folds one full four-byte word into the running hash.
   function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] h_in,
                                                  input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] h;
      logic [WORD_W-1:0] t;
      h = h_in + {{(WORD_W-HALF_W){1'b0}}, w[HALF_W-1:0]};
      t = ({{(WORD_W-HALF_W){1'b0}}, w[WORD_W-1:HALF_W]} << 11) ^ h;
      h = (h << 16) ^ t;
      h = h + (h >> 11);
      return h;
   endfunction

   // Full word, or the tail rule of a last item with 0 to 3 bytes.
   function automatic logic [WORD_W-1:0] mix_item(input logic [WORD_W-1:0]  h_in,
                                                  input logic [WORD_W-1:0]  w,
                                                  input logic [COUNT_W-1:0] n,
                                                  input logic               last,
                                                  input logic               sgn);
      logic [WORD_W-1:0] h;
      h = h_in;
      if (!last) begin
         h = mix_word(h_in, w);
      end else begin
         case (n)
            TAIL_NONE: begin
               h = h_in;
            end
            TAIL_ONE: begin
               h = h + single_byte(w[BYTE_W-1:0], sgn);
               h = h ^ (h << 10);
               h = h + (h >> 1);
            end
            TAIL_TWO: begin
               h = h + {{(WORD_W-HALF_W){1'b0}}, w[HALF_W-1:0]};
               h = h ^ (h << 11);
               h = h + (h >> 17);
            end
            TAIL_THREE: begin
               h = h + {{(WORD_W-HALF_W){1'b0}}, w[HALF_W-1:0]};
               h = h ^ (h << 16);
               h = h ^ (single_byte(w[HALF_W+BYTE_W-1:HALF_W], sgn) << 18);
               h = h + (h >> 11);
            end
            default: begin
               h = mix_word(h_in, w);
            end
         endcase
      end
      return h;
   endfunction

   // Six-step avalanche applied to the hash of a finished string.
   function automatic logic [WORD_W-1:0] finish(input logic [WORD_W-1:0] h_in);
      logic [WORD_W-1:0] h;
      h = h_in;
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      return h;
   endfunction

endpackage
`default_nettype wire

### hdl/sfsh_if.sv
// Interfaces: the request and response channels of the string hash.
`default_nettype none
interface sfsh_req_if;
   import sfsh_pkg::*;
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  data_word;
   logic [COUNT_W-1:0] byte_count;
   logic               last;

   modport source (output valid, output data_word, output byte_count, output last,
                   input ready);
   modport sink   (input valid, input data_word, input byte_count, input last,
                   output ready);
endinterface

interface sfsh_rsp_if;
   import sfsh_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

### hdl/sfsh_mix.sv
// Input register and mix stage; owns the running hash.
`default_nettype none
module sfsh_mix (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         bytes_signed,
   sfsh_req_if.sink          req_chan,
   output sfsh_pkg::tail_type mix_out,
   input  wire logic         fin_ready
);
   import sfsh_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [WORD_W-1:0]  in_word_ff, in_word_in;
   logic [COUNT_W-1:0] in_count_ff, in_count_in;
   logic               in_last_ff, in_last_in;
   logic [WORD_W-1:0]  run_hash_ff, run_hash_in;
   logic               tail_valid_ff, tail_valid_in;
   logic [WORD_W-1:0]  tail_hash_ff, tail_hash_in;
   logic [WORD_W-1:0]  mixed;
   logic               tail_ready;
   logic               advance;
   logic               take;

   assign mixed      = mix_item(run_hash_ff, in_word_ff, in_count_ff, in_last_ff, bytes_signed);
   assign tail_ready = !tail_valid_ff || fin_ready;
   // Middle words only touch the running hash; last items need a tail slot.
   assign advance    = in_valid_ff && (!in_last_ff || tail_ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      in_count_in = in_count_ff;
      in_last_in  = in_last_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_chan.data_word;
         in_count_in = req_chan.byte_count;
         in_last_in  = req_chan.last;
      end
   end

   always_comb begin
      run_hash_in = run_hash_ff;
      if (advance) begin
         run_hash_in = in_last_ff ? '0 : mixed;
      end
   end

   always_comb begin
      tail_valid_in = tail_valid_ff;
      tail_hash_in  = tail_hash_ff;
      if (tail_ready) begin
         tail_valid_in = in_valid_ff && in_last_ff;
         tail_hash_in  = mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         run_hash_ff   <= '0;
         tail_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         run_hash_ff   <= run_hash_in;
         tail_valid_ff <= tail_valid_in;
      end
      in_word_ff   <= in_word_in;
      in_count_ff  <= in_count_in;
      in_last_ff   <= in_last_in;
      tail_hash_ff <= tail_hash_in;
   end

   assign mix_out.valid = tail_valid_ff;
   assign mix_out.hash  = tail_hash_ff;

endmodule
`default_nettype wire

### hdl/sfsh_finish.sv
// Finish stage: avalanche and the response register.
`default_nettype none
module sfsh_finish (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire sfsh_pkg::tail_type mix_out,
   output logic               fin_ready,
   sfsh_rsp_if.source         rsp_chan
);
   import sfsh_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_hash_ff, rsp_hash_in;

   assign fin_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (fin_ready) begin
         rsp_valid_in = mix_out.valid;
         rsp_hash_in  = finish(mix_out.hash);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hash_value = rsp_hash_ff;

endmodule
`default_nettype wire

### hdl/super_fast_string_hash.sv
// Top level of the streaming string hash: config register and the two stages.
// Throughput: one item per cycle, sustained, as long as the response side keeps up.
// The hash of a string appears on the response channel once its last item has
// passed the input register, then the tail register, then the response register.
// Reset clears the running hash and all valid flags and sets bytes_signed to 1;
// no clearing pass is needed, so items are accepted right after reset is released.
`default_nettype none
module super_fast_string_hash (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic csr_write_data,
   sfsh_req_if.sink   req_chan,
   sfsh_rsp_if.source rsp_chan
);
   import sfsh_pkg::*;

   // The one configuration bit: whether single tail bytes are taken as signed char.
   logic bytes_signed_ff, bytes_signed_in;

   // The last item's pre-avalanche hash, handed from the mix stage to the finish
   // stage, and the finish stage's ready flag going back.
   tail_type mix_out;
   logic     fin_ready;

   always_comb begin
      bytes_signed_in = bytes_signed_ff;
      if (csr_write_enable) begin
         bytes_signed_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_signed_ff <= 1'b1;
      end else begin
         bytes_signed_ff <= bytes_signed_in;
      end
   end

   // The mix stage folds a middle item into the running hash in the cycle after it
   // is registered. Middle items never wait on the response side; only a last
   // item needs room in the tail register, and its departure clears the hash.
   sfsh_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .bytes_signed (bytes_signed_ff),
      .req_chan     (req_chan),
      .mix_out      (mix_out),
      .fin_ready    (fin_ready)
   );

   // The finish stage runs the avalanche and holds the result until it is taken;
   // while a result waits, the stages behind it accept items until a last item finds the tail register full.
   sfsh_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .mix_out   (mix_out),
      .fin_ready (fin_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

### tb/tb_super_fast_string_hash.sv
// Testbench for the streaming string hash: random and directed strings checked by a scoreboard.
module tb_super_fast_string_hash;
   timeunit 1ns;
   timeprecision 1ps;
   import sfsh_pkg::*;

   // The block answers through its input, tail and response registers. Leave some margin
   // before a register write or before the final verdict.
   localparam int unsigned SETTLE_CYCLES = 8;
   // Long receiver hold-off used to back the block up into its input.
   localparam int unsigned HOLD_CYCLES   = 200;
   // Several times the slowest correct run: about 475 items, each with the
   // longest sender gap, the longest receiver stall and the pipeline depth,
   // plus the long hold-off and the settling waits between phases.
   localparam int unsigned CYCLE_LIMIT   = 100000;
   localparam int unsigned PHASE_ITEMS   = 75;
   localparam int unsigned PHASE_COUNT   = 6;
   localparam int unsigned BURST_STRINGS = 40;

   // Scoreboard: keeps its own copy of the running hash and of the sign
   // setting, predicts the hash of each finished string and checks the hashes
   // in the order the strings were finished.
   class HashScoreboard;
      logic [WORD_W-1:0] running_hash;
      bit                signed_bytes;
      logic [WORD_W-1:0] string_hashes[$];
      int unsigned       errors;

      function new();
         running_hash = '0;
         signed_bytes = 1'b1;
         errors       = 0;
      endfunction

      // A lone tail byte is widened as signed or unsigned char.
      function logic [WORD_W-1:0] widen_byte(logic [BYTE_W-1:0] b);
         logic [WORD_W-1:0] wide;
         wide = {{(WORD_W-BYTE_W){1'b0}}, b};
         if (signed_bytes && b[BYTE_W-1])
            wide[WORD_W-1:BYTE_W] = '1;
         return wide;
      endfunction

      function void note_word(logic [WORD_W-1:0] w, logic [COUNT_W-1:0] n, logic is_last);
         logic [WORD_W-1:0] h;
         logic [WORD_W-1:0] upper;
         h = running_hash;
         if (!is_last || n >= 3'd4) begin
            // Full word: low half added, high half folded in above bit 11.
            upper = {{(WORD_W-HALF_W){1'b0}}, w[WORD_W-1:HALF_W]};
            h = h + {{(WORD_W-HALF_W){1'b0}}, w[HALF_W-1:0]};
            h = (h << 16) ^ ((upper << 11) ^ h);
            h = h + (h >> 11);
            if (!is_last) begin
               running_hash = h;
               return;
            end
         end else begin
            case (n)
               TAIL_THREE: begin
                  h = h + {{(WORD_W-HALF_W){1'b0}}, w[HALF_W-1:0]};
                  h = h ^ (h << 16);
                  h = h ^ (widen_byte(w[HALF_W+BYTE_W-1:HALF_W]) << 18);
                  h = h + (h >> 11);
               end
               TAIL_TWO: begin
                  h = h + {{(WORD_W-HALF_W){1'b0}}, w[HALF_W-1:0]};
                  h = h ^ (h << 11);
                  h = h + (h >> 17);
               end
               TAIL_ONE: begin
                  h = h + widen_byte(w[BYTE_W-1:0]);
                  h = h ^ (h << 10);
                  h = h + (h >> 1);
               end
               default: ;  // empty tail: nothing more to mix
            endcase
         end
         // Avalanche of the finished string.
         h = h ^ (h << 3);
         h = h + (h >> 5);
         h = h ^ (h << 4);
         h = h + (h >> 17);
         h = h ^ (h << 25);
         h = h + (h >> 6);
         string_hashes.push_back(h);
         running_hash = '0;
      endfunction

      function void check_hash(logic [WORD_W-1:0] got);
         logic [WORD_W-1:0] want;
         if (string_hashes.size() == 0) begin
            errors++;
            $display("%0t: hash %h arrived with no finished string waiting", $time, got);
            return;
         end
         want = string_hashes.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: hash_value mismatch, expected %h, actual %h", $time, want, got);
         end
      endfunction

      function int unsigned pending();
         return string_hashes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data   = 1'b0;

   sfsh_req_if req_chan();
   sfsh_rsp_if rsp_chan();

   HashScoreboard sb = new();

   // Idle behavior of both sides, switched per phase by the stimulus.
   bit          send_gaps   = 1'b1;
   bit          recv_gaps   = 1'b1;
   bit          hold_rsp    = 1'b0;
   int unsigned sent_items  = 0;
   int unsigned cycle_count = 0;

   super_fast_string_hash u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   always #1 clock = ~clock;

   // All request inputs start at known values; reset is held high from the start
   // and then released on a falling edge, once and for good.
   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.data_word  <= '0;
      req_chan.byte_count <= '0;
      req_chan.last       <= 1'b0;
      rsp_chan.ready      <= 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Offers one item after a random gap and waits until the block takes it.
   // Inputs change on the falling edge; ready is sampled on the rising edge.
   task automatic send_item(input logic [WORD_W-1:0] w, input logic [COUNT_W-1:0] n,
                            input logic is_last);
      int unsigned gap;
      gap = send_gaps ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_word  <= w;
      req_chan.byte_count <= n;
      req_chan.last       <= is_last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_word(w, n, is_last);
      sent_items++;
   endtask

   // Drops valid, waits for every expected hash and lets the pipeline empty,
   // since a trailing partial string would leave no expectation behind.
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The sign setting is only changed while the block is idle.
   task automatic write_signed(input bit value);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.signed_bytes = value;
   endtask

   // Random words lean toward the extremes now and then.
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return {4{8'h80}};
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed strings: full words with byte_count 4, then a tail of
   // 0 to 4 bytes. One string in ten is noise: random byte counts of 0 to 7 on
   // about half of its inner words and on its tail.
   task automatic send_string(input int unsigned words);
      bit          noise;
      int unsigned i;
      noise = ($urandom_range(0, 9) == 0);
      for (i = 0; i < words; i++)
         send_item(pick_word(), (noise && $urandom_range(0, 1)) ? 3'($urandom_range(0, 7)) : 3'd4,
                   1'b0);
      send_item(pick_word(), noise ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4)), 1'b1);
   endtask

   // Receiver: draws a stall before each hash, sometimes extended by a long
   // hold-off, then keeps ready high until a hash is taken.
   initial begin
      int unsigned stall;
      @(negedge reset);
      forever begin
         stall = recv_gaps ? $urandom_range(0, 7) : 0;
         if (hold_rsp) begin
            stall    = stall + HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         sb.check_hash(rsp_chan.hash_value);
      end
   end

   // Main stimulus: a directed opening, then random phases that each start
   // with a register write and pick their own idle pattern.
   initial begin
      int unsigned phase;
      int unsigned phase_end;
      int unsigned burst;
      @(negedge reset);

      // The empty string, and each tail length with signed bytes (reset value).
      send_item(32'h0000_0000, TAIL_NONE, 1'b1);
      send_item(32'hFFFF_FF80, TAIL_ONE, 1'b1);
      send_item(32'h0000_007F, TAIL_ONE, 1'b1);
      send_item(32'h1234_FFFF, TAIL_TWO, 1'b1);
      send_item(32'hFF80_FFFF, TAIL_THREE, 1'b1);
      send_item(32'h0000_0000, TAIL_THREE, 1'b1);
      // Last item carrying a full word, and the out-of-range counts 5 to 7.
      send_item(32'hFFFF_FFFF, 3'd4, 1'b1);
      send_item(32'h0000_0000, 3'd4, 1'b1);
      send_item(32'hA5A5_5A5A, 3'd5, 1'b1);
      send_item(32'h5A5A_A5A5, 3'd6, 1'b1);
      send_item(32'hFFFF_FFFF, 3'd7, 1'b1);
      // Inner words with a byte count other than 4 still mix as full words.
      send_item(32'hFFFF_FFFF, 3'd0, 1'b0);
      send_item(32'h8000_0001, 3'd7, 1'b0);
      send_item(32'h00FF_00FF, TAIL_ONE, 1'b1);
      // A multi-word string that ends in an empty last item.
      send_item(32'hDEAD_BEEF, 3'd4, 1'b0);
      send_item(32'hFFFF_FFFF, 3'd4, 1'b0);
      send_item(32'h0000_0000, TAIL_NONE, 1'b1);

      // Same single-byte cases with bytes treated as unsigned.
      write_signed(1'b0);
      send_item(32'hFFFF_FF80, TAIL_ONE, 1'b1);
      send_item(32'h00FF_1234, TAIL_THREE, 1'b1);
      send_item(32'hFFFF_FFFF, TAIL_ONE, 1'b1);
      send_item(32'h8080_FFFF, TAIL_THREE, 1'b1);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         write_signed(phase < 4 ? phase[0] : 1'($urandom_range(0, 1)));
         case (phase % 4)
            0: begin send_gaps = 1'b1; recv_gaps = 1'b1; end
            1: begin send_gaps = 1'b0; recv_gaps = 1'b0; end
            2: begin send_gaps = 1'b1; recv_gaps = 1'b0; end
            default: begin send_gaps = 1'b0; recv_gaps = 1'b1; end
         endcase
         phase_end = sent_items + PHASE_ITEMS;

         // Once, the receiver holds off for a long stretch while the sender
         // keeps offering one-word strings back to back, so the block fills
         // and must stall its input.
         if (phase == 2) begin
            send_gaps = 1'b0;
            hold_rsp  = 1'b1;
            for (burst = 0; burst < BURST_STRINGS; burst++)
               send_item(pick_word(), 3'($urandom_range(0, 4)), 1'b1);
            send_gaps = 1'b1;
         end

         while (sent_items < phase_end)
            send_string(($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                    : $urandom_range(0, 3));
      end

      settle();
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule
